// File: sv/assert_macros.svh
// Assertion helpers for the page allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CPBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define CPBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CPBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CPBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/cpba_pkg.sv
`timescale 1ns / 1ps
package cpba_pkg;
  localparam int VIRT_PAGES  = 2048;
  localparam int PHYS_FRAMES = 1024;
  localparam int MEM_FRAMES  = 256;
  localparam int MEM_BOUND   = (MEM_FRAMES < PHYS_FRAMES) ? MEM_FRAMES : PHYS_FRAMES;
  localparam int DISK_BOUND  = PHYS_FRAMES - MEM_BOUND;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int NWORDS      = VIRT_PAGES / WORD_W;
  localparam int WIDX_W      = $clog2(NWORDS);
  localparam int VP_W        = 11;
  localparam int PP_W        = 10;
  localparam int CNT_W       = 12;
  localparam int MEMC_W      = 9;
  localparam int DISKC_W     = 10;
  localparam int VA_W        = $clog2(VIRT_PAGES);
  localparam int PA_W        = $clog2(PHYS_FRAMES);
  localparam int RUN_W       = $clog2(VIRT_PAGES + 1);

  typedef enum logic [1:0] {
    KIND_FIND  = 2'd0,
    KIND_MAP   = 2'd1,
    KIND_UNMAP = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_RDWD  = 6'b000100,
    ST_UPD   = 6'b001000,
    ST_WAITO = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  typedef struct packed {
    logic start_find;
    logic scan_step;
    logic rd_word;
    logic do_update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic quick;
  } sts_t;
endpackage

// File: sv/cpba_datapath.sv
`timescale 1ns / 1ps
module cpba_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpba_pkg::cmd_t            cmd,
  output cpba_pkg::sts_t            sts,
  input  logic [1:0]                kind,
  input  logic [cpba_pkg::VP_W-1:0] virt_page,
  input  logic [cpba_pkg::PP_W-1:0] phys_page,
  input  logic [cpba_pkg::CNT_W-1:0] page_count,
  output logic                      res_status,
  output logic [cpba_pkg::VP_W-1:0] res_found,
  output logic [cpba_pkg::MEMC_W-1:0] res_mem,
  output logic [cpba_pkg::DISKC_W-1:0] res_disk
);
  import cpba_pkg::*;
  `include "assert_macros.svh"

  // virtual bitmap as words, bit 0 of a word is the lowest page
  logic [WORD_W-1:0] vmap_mem [NWORDS];
  logic [NWORDS-1:0] vvalid_r;
  logic [PP_W-1:0] frame_mem [VIRT_PAGES];
  logic [WORD_W-1:0] vword_r;
  logic [WORD_W-1:0] sword_r;
  logic [PP_W-1:0] frame_r;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic found_r, found_nxt, done_r, done_nxt;
  logic [VP_W-1:0] start_r, start_nxt;
  logic [MEMC_W-1:0] memc_r;
  logic [DISKC_W-1:0] diskc_r;
  logic [1:0] kind_r;
  logic [VP_W-1:0] vp_r;
  logic [PP_W-1:0] pp_r;
  logic [CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0] scan_word;
  logic vp_ok, pp_ok, vused;
  logic [WIDX_W-1:0] vp_widx;
  logic [BIT_W-1:0] vp_bit;
  logic [RUN_W-1:0] r;
  logic [RUN_W-1:0] run_b;
  logic [BIT_W:0] last_used;
  logic hit;
  logic [VP_W-1:0] hit_start;

  assign vp_ok   = ({1'b0, vp_r} < (VP_W+1)'(VIRT_PAGES));
  assign pp_ok   = ({1'b0, pp_r} < (PP_W+1)'(PHYS_FRAMES));
  assign vp_widx = vp_r[VA_W-1:BIT_W];
  assign vp_bit  = vp_r[BIT_W-1:0];
  assign vused   = vword_r[vp_bit];

  assign sts.quick     = (kind_r == KIND_FIND) &&
                         (cnt_r == '0 || {1'b0, cnt_r} > (CNT_W+1)'(VIRT_PAGES));
  assign sts.scan_done = done_r;

  // scan one word per cycle: the run ending at each bit is the carried run
  // while the word is free up to it, else the distance past the last used bit
  always_comb begin
    scan_word = sword_r;
    last_used = '0;
    run_b = run_r;
    r = run_r;
    hit = 1'b0;
    hit_start = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (scan_word[b]) begin
        last_used = (BIT_W+1)'(b + 1);
      end
      if (last_used == '0) begin
        run_b = run_r + RUN_W'(b + 1);
      end else begin
        run_b = RUN_W'(b + 1) - RUN_W'(last_used);
      end
      if (!hit && run_b >= cnt_r) begin
        hit = 1'b1;
        hit_start = (last_used == '0) ? VP_W'(RUN_W'({widx_r, BIT_W'(0)}) - run_r)
                                      : {widx_r, last_used[BIT_W-1:0]};
      end
      r = run_b;
    end
  end

  always_comb begin
    widx_nxt = widx_r;
    run_nxt = run_r;
    found_nxt = found_r;
    start_nxt = start_r;
    done_nxt = done_r;
    if (cmd.start_find) begin
      widx_nxt = '0;
      run_nxt = '0;
      found_nxt = 1'b0;
      start_nxt = '0;
      done_nxt = 1'b0;
    end else if (cmd.scan_step && !done_r) begin
      run_nxt = r;
      widx_nxt = widx_r + 1'b1;
      if (hit) begin
        found_nxt = 1'b1;
        start_nxt = hit_start;
        done_nxt = 1'b1;
      end else if (widx_r == WIDX_W'(NWORDS-1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      run_r <= '0;
      found_r <= 1'b0;
      start_r <= '0;
      done_r <= 1'b0;
    end else begin
      widx_r <= widx_nxt;
      run_r <= run_nxt;
      found_r <= found_nxt;
      start_r <= start_nxt;
      done_r <= done_nxt;
    end
  end

  // prefetch the word that the scan looks at next cycle
  always_ff @(posedge clk) begin
    sword_r <= vvalid_r[widx_nxt] ? vmap_mem[widx_nxt] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.start_find) begin
      kind_r <= kind;
      vp_r <= virt_page;
      pp_r <= phys_page;
      cnt_r <= page_count;
    end
  end

  // fetch the bitmap word and recorded frame of the target page
  always_ff @(posedge clk) begin
    if (cmd.rd_word) begin
      vword_r <= vvalid_r[vp_widx] ? vmap_mem[vp_widx] : '0;
      frame_r <= frame_mem[vp_r[VA_W-1:0]];
    end
  end

  logic upd_map, upd_unmap;
  logic [WORD_W-1:0] wr_word;
  assign upd_map   = cmd.do_update && kind_r == KIND_MAP && vp_ok && pp_ok;
  assign upd_unmap = cmd.do_update && kind_r == KIND_UNMAP && vp_ok && vused;
  always_comb begin
    wr_word = vword_r;
    wr_word[vp_bit] = upd_map;
  end

  always_ff @(posedge clk) begin
    if (upd_map || upd_unmap) begin
      vmap_mem[vp_widx] <= wr_word;
    end
    if (upd_map) begin
      frame_mem[vp_r[VA_W-1:0]] <= pp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vvalid_r <= '0;
      memc_r <= MEMC_W'(MEM_BOUND);
      diskc_r <= DISKC_W'(DISK_BOUND);
    end else begin
      if (upd_map || upd_unmap) begin
        vvalid_r[vp_widx] <= 1'b1;
      end
      if (upd_map) begin
        if ({1'b0, pp_r} < (PP_W+1)'(MEM_BOUND)) begin
          if (memc_r != '0) memc_r <= memc_r - 1'b1;
        end else if (diskc_r != '0) begin
          diskc_r <= diskc_r - 1'b1;
        end
      end
      if (upd_unmap) begin
        if ({1'b0, frame_r} < (PP_W+1)'(MEM_BOUND)) begin
          if (memc_r != MEMC_W'(MEM_BOUND)) memc_r <= memc_r + 1'b1;
        end else if (diskc_r != DISKC_W'(DISK_BOUND)) begin
          diskc_r <= diskc_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_mem  <= memc_r;
      res_disk <= diskc_r;
      unique case (kind_r)
        KIND_FIND: begin
          if (cnt_r == '0) begin
            res_status <= 1'b0;
            res_found  <= '0;
          end else begin
            res_status <= !found_r || sts.quick;
            res_found  <= (found_r && !sts.quick) ? start_r : '0;
          end
        end
        KIND_MAP: begin
          res_status <= !(vp_ok && pp_ok);
          res_found  <= '0;
        end
        KIND_UNMAP: begin
          res_status <= !(vp_ok && vused);
          res_found  <= '0;
        end
        default: begin
          res_status <= 1'b1;
          res_found  <= '0;
        end
      endcase
    end
  end

  `CPBA_ASSERT_IMP(a_mem_bound, clk, rst_n, 1'b1, memc_r <= MEMC_W'(MEM_BOUND), "mem count over bound")
  `CPBA_ASSERT_IMP(a_disk_bound, clk, rst_n, 1'b1, diskc_r <= DISKC_W'(DISK_BOUND), "disk count over bound")
  `CPBA_ASSERT_NXT(a_done_holds, clk, rst_n, done_r && cmd.scan_step, done_r, "scan done dropped")
endmodule

// File: sv/cpba_ctrl.sv
`timescale 1ns / 1ps
module cpba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [1:0]     kind,
  input  cpba_pkg::sts_t sts,
  output cpba_pkg::cmd_t cmd,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready
);
  import cpba_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;
  logic ovalid_r, ovalid_nxt;

  always_comb begin
    state_nxt = state_r;
    ovalid_nxt = ovalid_r;
    cmd = '0;
    if (out_valid && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.start_find = 1'b1;
          state_nxt = (kind == KIND_FIND) ? ST_SCAN : ST_RDWD;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done || sts.quick) state_nxt = ST_WAITO;
      end
      ST_RDWD: begin
        cmd.rd_word = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.do_update = 1'b1;
        state_nxt = ST_WAITO;
      end
      ST_WAITO: begin
        // hold until the output register is free
        if (!ovalid_nxt) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.load_out = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ovalid_r;

  `CPBA_ASSERT_NXT(a_load_sets_valid, clk, rst_n, cmd.load_out, ovalid_r, "result not shown")
  `CPBA_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, !ovalid_r || out_ready, "result overwritten")
  `CPBA_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_r), "state not one-hot")
endmodule

// File: sv/contiguous_page_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// Map/unmap pass through the read, update, wait and output states; find scans one word
// of 32 bitmap bits per cycle through the scan unit, then waits for the output register.
// One item at a time; the next is taken once the result is in the output register.
// Reset (rst_n, synchronous, low): page bitmap reads as clear, counters at bounds.
module contiguous_page_bitmap_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // kind[1:0], virt_page[12:2], phys_page[22:13], page_count[34:23]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata  // status[0], found_page[11:1], free_mem_frames[20:12], free_disk_frames[30:21]
);
  import cpba_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic res_status;
  logic [VP_W-1:0] res_found;
  logic [MEMC_W-1:0] res_mem;
  logic [DISKC_W-1:0] res_disk;

  cpba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready), .kind(in_tdata[1:0]),
    .sts(sts), .cmd(cmd), .in_ready(in_tready), .out_valid(out_tvalid),
    .out_ready(out_tready)
  );

  cpba_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .kind(in_tdata[1:0]), .virt_page(in_tdata[12:2]), .phys_page(in_tdata[22:13]),
    .page_count(in_tdata[34:23]),
    .res_status(res_status), .res_found(res_found), .res_mem(res_mem), .res_disk(res_disk)
  );

  assign out_tdata = {1'b0, res_disk, res_mem, res_found, res_status};
endmodule

// File: verif/contiguous_page_bitmap_allocator_unit_tb.sv
`timescale 1ns / 1ps
module contiguous_page_bitmap_allocator_unit_tb;
  import cpba_pkg::*;

  typedef struct packed {
    logic [9:0]  disk_free;
    logic [8:0]  mem_free;
    logic [10:0] found;
    logic        status;
  } alloc_result_t;

  typedef struct {
    kind_t       kind;
    logic [10:0] vpage;
    logic [9:0]  ppage;
    logic [11:0] count;
    logic        has_exp;
    logic        exp_status;
    logic [10:0] exp_found;
  } stim_row_t;

  localparam int LIMIT_CYCLES = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  contiguous_page_bitmap_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  // predictor state
  bit           page_used [VIRT_PAGES];
  bit           frame_used [PHYS_FRAMES];
  logic [9:0]   page_frame [VIRT_PAGES];
  int unsigned  mem_free;
  int unsigned  disk_free;

  alloc_result_t pending_results[$];
  logic          pending_has_fixed[$];
  logic [11:0]   pending_fixed[$];
  int            errors = 0;
  longint        cycles = 0;
  int            mapped_pages[$];

  function automatic alloc_result_t predict_alloc(kind_t k, logic [10:0] vp,
                                                  logic [9:0] pp, logic [11:0] cnt);
    alloc_result_t r;
    int run;
    int f;
    r = '0;
    r.status = 1'b1;
    run = 0;
    case (k)
      KIND_FIND: begin
        if (cnt == 0) begin
          r.status = 1'b0;
        end else if (cnt <= VIRT_PAGES) begin
          for (int v = 0; v < VIRT_PAGES; v++) begin
            if (page_used[v]) begin
              run = 0;
            end else begin
              run++;
              if (run >= cnt) begin
                r.status = 1'b0;
                r.found = 11'(v + 1 - run);
                break;
              end
            end
          end
        end
      end
      KIND_MAP: begin
        page_used[vp] = 1'b1;
        frame_used[pp] = 1'b1;
        page_frame[vp] = pp;
        if (pp < MEM_BOUND) begin
          if (mem_free > 0) mem_free--;
        end else if (disk_free > 0) begin
          disk_free--;
        end
        r.status = 1'b0;
      end
      KIND_UNMAP: begin
        if (page_used[vp]) begin
          f = page_frame[vp];
          page_used[vp] = 1'b0;
          frame_used[f] = 1'b0;
          if (f < MEM_BOUND) begin
            if (mem_free < MEM_BOUND) mem_free++;
          end else if (disk_free < DISK_BOUND) begin
            disk_free++;
          end
          r.status = 1'b0;
        end
      end
      default: ;
    endcase
    r.mem_free = mem_free[8:0];
    r.disk_free = disk_free[9:0];
    return r;
  endfunction

  // drive one word, with the sender's burst/gap pattern
  int burst_left = 0;
  task automatic send_word(kind_t k, logic [10:0] vp, logic [9:0] pp, logic [11:0] cnt,
                           logic fixed_on, logic fixed_status, logic [10:0] fixed_found);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, cnt, pp, vp, k};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_alloc(k, vp, pp, cnt));
    pending_has_fixed.push_back(fixed_on);
    pending_fixed.push_back({fixed_found, fixed_status});
    if (k == KIND_MAP) mapped_pages.push_back(vp);
  endtask

  // drop valid before the sender pauses
  task automatic release_bus();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stall pattern
  int stall_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 3000 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((cycles % 7) < 4);
    endcase
  end

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    logic [11:0] fx;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[30:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        fx = pending_fixed.pop_front();
        if (pending_has_fixed.pop_front() && fx != {want.found, want.status}) begin
          $display("%0t: table entry, expected status %0d page %0d, predicted %0d %0d",
                   $time, fx[0], fx[11:1], want.status, want.found);
          errors++;
        end
        if (got.status !== want.status || got.found !== want.found ||
            got.mem_free !== want.mem_free || got.disk_free !== want.disk_free) begin
          $display("%0t: expected st=%0d pg=%0d mem=%0d disk=%0d, actual st=%0d pg=%0d mem=%0d disk=%0d",
                   $time, want.status, want.found, want.mem_free, want.disk_free,
                   got.status, got.found, got.mem_free, got.disk_free);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL contiguous_page_bitmap_allocator_unit");
      $finish;
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t row(kind_t k, int vp, int pp, int cnt,
                                    int h, int s, int fp);
    stim_row_t r;
    r.kind = k; r.vpage = 11'(vp); r.ppage = 10'(pp); r.count = 12'(cnt);
    r.has_exp = (h != 0); r.exp_status = (s != 0); r.exp_found = 11'(fp);
    return r;
  endfunction

  initial begin
    int vp;
    int idx;
    int pick;
    mem_free = MEM_BOUND;
    disk_free = DISK_BOUND;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(row(KIND_FIND, 0, 0, 0, 1, 0, 0));        // empty request
    directed.push_back(row(KIND_FIND, 0, 0, 2048, 1, 0, 0));     // whole space free
    directed.push_back(row(KIND_FIND, 0, 0, 2049, 1, 1, 0));     // too long
    directed.push_back(row(KIND_FIND, 0, 0, 4095, 1, 1, 0));
    directed.push_back(row(KIND_UNMAP, 5, 0, 0, 1, 1, 0));       // unmapped page
    directed.push_back(row(KIND_NONE, 2047, 1023, 4095, 1, 1, 0));
    directed.push_back(row(KIND_MAP, 0, 0, 0, 1, 0, 0));
    directed.push_back(row(KIND_MAP, 2047, 1023, 4095, 1, 0, 0));
    directed.push_back(row(KIND_MAP, 3, 255, 0, 1, 0, 0));
    directed.push_back(row(KIND_MAP, 3, 256, 0, 1, 0, 0));       // remap
    directed.push_back(row(KIND_FIND, 0, 0, 1, 1, 0, 1));
    directed.push_back(row(KIND_FIND, 0, 0, 3, 0, 0, 0));
    directed.push_back(row(KIND_FIND, 0, 0, 2046, 1, 1, 0));
    directed.push_back(row(KIND_FIND, 0, 0, 2043, 1, 0, 4));
    directed.push_back(row(KIND_UNMAP, 3, 0, 0, 1, 0, 0));
    directed.push_back(row(KIND_UNMAP, 3, 0, 0, 1, 1, 0));
    directed.push_back(row(KIND_UNMAP, 2047, 682, 1365, 1, 0, 0));
    directed.push_back(row(KIND_UNMAP, 0, 0, 0, 1, 0, 0));
    directed.push_back(row(KIND_FIND, 1365, 341, 2048, 1, 0, 0));
    foreach (directed[i])
      send_word(directed[i].kind, directed[i].vpage, directed[i].ppage, directed[i].count,
                directed[i].has_exp, directed[i].exp_status, directed[i].exp_found);

    // drain the memory counter to zero and past it, then refill it to its bound and past it
    for (int i = 0; i < 260; i++)
      send_word(KIND_MAP, 11'(100 + i), 10'(i % 256), 12'd0, 1'b0, 1'b0, 11'd0);
    release_bus();
    wait (pending_results.size() == 0);
    for (int i = 0; i < 262; i++)
      send_word(KIND_UNMAP, 11'(100 + i), 10'd0, 12'd0, 1'b0, 1'b0, 11'd0);

    for (int n = 0; n < 460; n++) begin
      if (n == 230) begin
        release_bus();
        wait (pending_results.size() == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // mapped pages cluster low so finds see fragmented space
        vp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 127);
        send_word(KIND_MAP, 11'(vp), 10'($urandom_range(0, 1023)), 12'($urandom),
                  1'b0, 1'b0, 11'd0);
      end else if (pick < 60) begin
        if (mapped_pages.size() > 0 && $urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, mapped_pages.size() - 1);
          vp = mapped_pages[idx];
          mapped_pages.delete(idx);
        end else begin
          vp = $urandom_range(0, 2047);
        end
        send_word(KIND_UNMAP, 11'(vp), 10'($urandom), 12'($urandom), 1'b0, 1'b0, 11'd0);
      end else if (pick < 95) begin
        send_word(KIND_FIND, 11'($urandom), 10'($urandom),
                  12'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, 40)),
                  1'b0, 1'b0, 11'd0);
      end else begin
        send_word(KIND_NONE, 11'($urandom), 10'($urandom), 12'($urandom),
                  1'b0, 1'b0, 11'd0);
      end
    end

    release_bus();
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS contiguous_page_bitmap_allocator_unit");
    end else begin
      $display("FAIL contiguous_page_bitmap_allocator_unit");
    end
    $finish;
  end
endmodule
